// File: hdl/apm_pkg.sv
// apm_pkg: shared types and codes for the attribute predicate matcher
// relation codes, operation codes and the controller/datapath command and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apm_pkg;

  localparam int KEY_W = 8;
  localparam int REL_W = 4;
  localparam int VAL_W = 16;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // relation codes, anything above REL_EQ_ANY is unknown
  localparam logic [REL_W-1:0] REL_IS     = 4'd0;
  localparam logic [REL_W-1:0] REL_EQ     = 4'd1;
  localparam logic [REL_W-1:0] REL_NE     = 4'd2;
  localparam logic [REL_W-1:0] REL_GT     = 4'd3;
  localparam logic [REL_W-1:0] REL_GE     = 4'd4;
  localparam logic [REL_W-1:0] REL_LT     = 4'd5;
  localparam logic [REL_W-1:0] REL_LE     = 4'd6;
  localparam logic [REL_W-1:0] REL_EQ_ANY = 4'd7;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic scan;
    logic finish;
  } apm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } apm_stat_t;

endpackage

`default_nettype wire

// File: hdl/attribute_predicate_match_top.sv
// attribute_predicate_match_top: candidate attribute store and reference matcher
// a load passes through the load state; a test passes through scan, then finish, the scan visiting
// one stored entry per step up to min(candidates, MAX_ATTRS), ends at first hit, at once for IS or an empty set
// out_valid pulses once, registered from the finish of the last test transfer; busy is high meanwhile
// rst_n is synchronous: counts clear, the candidate set opens, the store itself is not cleared
// depends on apm_pkg, apm_ctrl, apm_datapath
`timescale 1ns / 1ps
`default_nettype none

module attribute_predicate_match_top #(
  parameter int MAX_ATTRS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_op,
  input  wire logic [apm_pkg::KEY_W-1:0]        in_attr_key,
  input  wire logic [apm_pkg::REL_W-1:0]        in_relation,
  input  wire logic signed [apm_pkg::VAL_W-1:0] in_attr_value,
  input  wire logic                             in_last,
  output logic                                  out_valid,
  output logic                                  out_matched,
  output logic                                  out_size_error
);

  apm_pkg::apm_cmd_t  cmd;
  apm_pkg::apm_stat_t stat;

  apm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op_i   (in_op),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  apm_datapath #(
    .MAX_ATTRS (MAX_ATTRS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .in_op          (in_op),
    .in_attr_key    (in_attr_key),
    .in_relation    (in_relation),
    .in_attr_value  (in_attr_value),
    .in_last        (in_last),
    .stat_o         (stat),
    .out_valid      (out_valid),
    .out_matched    (out_matched),
    .out_size_error (out_size_error)
  );

endmodule

`default_nettype wire

// File: hdl/apm_ctrl.sv
// apm_ctrl: sequencer for the attribute predicate matcher
// issues capture, load, scan and finish commands to apm_datapath
// depends on apm_pkg
`timescale 1ns / 1ps
`default_nettype none

module apm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              op_i,
  input  wire apm_pkg::apm_stat_t stat_i,
  output apm_pkg::apm_cmd_t      cmd_o,
  output logic                   busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (op_i == apm_pkg::OP_LOAD) ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy_o         = (state_r != ST_IDLE);
  assign cmd_o.capture  = (state_r == ST_IDLE) && start;
  assign cmd_o.load     = (state_r == ST_LOAD);
  assign cmd_o.scan     = (state_r == ST_SCAN);
  assign cmd_o.finish   = (state_r == ST_FINISH);

  // a test always passes through finish right after its scan ends
  a_scan_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.scan && stat_i.scan_done) |=> cmd_o.finish)
    else $error("scan end not followed by finish");

  // a transfer is only taken while idle
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.capture |=> busy_o)
    else $error("busy not raised after transfer");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.capture, cmd_o.load, cmd_o.scan, cmd_o.finish}))
    else $error("overlapping commands");

endmodule

`default_nettype wire

// File: hdl/apm_datapath.sv
// apm_datapath: candidate store, counters and the per-entry compare unit
// walks stored candidates one per cycle under commands from apm_ctrl
// depends on apm_pkg
`timescale 1ns / 1ps
`default_nettype none

module apm_datapath #(
  parameter int MAX_ATTRS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire apm_pkg::apm_cmd_t                cmd_i,
  input  wire logic                             in_op,
  input  wire logic [apm_pkg::KEY_W-1:0]        in_attr_key,
  input  wire logic [apm_pkg::REL_W-1:0]        in_relation,
  input  wire logic signed [apm_pkg::VAL_W-1:0] in_attr_value,
  input  wire logic                             in_last,
  output apm_pkg::apm_stat_t                    stat_o,
  output logic                                  out_valid,
  output logic                                  out_matched,
  output logic                                  out_size_error
);

  localparam int CNT_W = $clog2(MAX_ATTRS + 2);
  localparam int IDX_W = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ATTRS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // captured item
  logic                             item_op_r;
  logic [apm_pkg::KEY_W-1:0]        item_key_r;
  logic [apm_pkg::REL_W-1:0]        item_rel_r;
  logic signed [apm_pkg::VAL_W-1:0] item_val_r;
  logic                             item_last_r;

  // candidate store, entries only used below the fill count
  logic [apm_pkg::KEY_W-1:0]        keys_r [MAX_ATTRS];
  logic [apm_pkg::REL_W-1:0]        rels_r [MAX_ATTRS];
  logic signed [apm_pkg::VAL_W-1:0] vals_r [MAX_ATTRS];

  logic [CNT_W-1:0] cand_count_r, cand_count_nxt;
  logic             cand_closed_r, cand_closed_nxt;
  logic [CNT_W-1:0] ref_count_r, ref_count_nxt;
  logic             all_matched_r, all_matched_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic             out_size_error_r, out_size_error_nxt;

  logic [CNT_W-1:0]                 n_cnt;
  logic [CNT_W-1:0]                 idx_ext;
  logic                             at_end;
  logic [apm_pkg::KEY_W-1:0]        rd_key;
  logic [apm_pkg::REL_W-1:0]        rd_rel;
  logic signed [apm_pkg::VAL_W-1:0] rd_val;
  logic                             rel_ok;
  logic                             scan_hit;
  logic [CNT_W-1:0]                 base;
  logic                             wr_en;
  logic [CNT_W-1:0]                 ref_inc;
  logic                             all_new;
  logic                             err;

  always_comb begin
    n_cnt   = (cand_count_r < CNT_MAX) ? cand_count_r : CNT_MAX;
    idx_ext = CNT_W'(idx_r);
    at_end  = (idx_ext + CNT_ONE) >= n_cnt;
    rd_key  = keys_r[idx_r];
    rd_rel  = rels_r[idx_r];
    rd_val  = vals_r[idx_r];

    case (item_rel_r)
      apm_pkg::REL_EQ:     rel_ok = (rd_val == item_val_r);
      apm_pkg::REL_NE:     rel_ok = (rd_val != item_val_r);
      apm_pkg::REL_GT:     rel_ok = (rd_val >  item_val_r);
      apm_pkg::REL_GE:     rel_ok = (rd_val >= item_val_r);
      apm_pkg::REL_LT:     rel_ok = (rd_val <  item_val_r);
      apm_pkg::REL_LE:     rel_ok = (rd_val <= item_val_r);
      apm_pkg::REL_EQ_ANY: rel_ok = 1'b1;
      default:             rel_ok = 1'b0;
    endcase

    scan_hit = (idx_ext < n_cnt) && (rd_key == item_key_r) &&
               (rd_rel == apm_pkg::REL_IS) && rel_ok;
    stat_o.scan_done = hit_r || scan_hit || at_end;

    // a load after a closed set starts a new one
    base  = cand_closed_r ? '0 : cand_count_r;
    wr_en = cmd_i.load && (base < CNT_MAX);

    ref_inc = (ref_count_r <= CNT_MAX) ? ref_count_r + CNT_ONE : ref_count_r;
    all_new = all_matched_r && hit_r;
    err     = (cand_count_r == '0) || (cand_count_r > CNT_MAX) ||
              (ref_inc == '0) || (ref_inc > CNT_MAX);

    cand_count_nxt     = cand_count_r;
    cand_closed_nxt    = cand_closed_r;
    ref_count_nxt      = ref_count_r;
    all_matched_nxt    = all_matched_r;
    idx_nxt            = idx_r;
    hit_nxt            = hit_r;
    out_valid_nxt      = 1'b0;
    out_matched_nxt    = out_matched_r;
    out_size_error_nxt = out_size_error_r;

    if (cmd_i.capture) begin
      idx_nxt = '0;
      hit_nxt = (in_relation == apm_pkg::REL_IS);
    end

    if (cmd_i.load) begin
      cand_count_nxt  = (base <= CNT_MAX) ? base + CNT_ONE : base;
      cand_closed_nxt = item_last_r;
    end

    if (cmd_i.scan) begin
      hit_nxt = hit_r || scan_hit;
      if (!at_end) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end

    if (cmd_i.finish) begin
      cand_closed_nxt = 1'b1;
      ref_count_nxt   = ref_inc;
      all_matched_nxt = all_new;
      if (item_last_r) begin
        out_valid_nxt      = 1'b1;
        out_matched_nxt    = all_new && !err;
        out_size_error_nxt = err;
        ref_count_nxt      = '0;
        all_matched_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      item_op_r   <= in_op;
      item_key_r  <= in_attr_key;
      item_rel_r  <= in_relation;
      item_val_r  <= in_attr_value;
      item_last_r <= in_last;
    end
    if (wr_en) begin
      keys_r[base[IDX_W-1:0]] <= item_key_r;
      rels_r[base[IDX_W-1:0]] <= item_rel_r;
      vals_r[base[IDX_W-1:0]] <= item_val_r;
    end
    idx_r            <= idx_nxt;
    hit_r            <= hit_nxt;
    out_matched_r    <= out_matched_nxt;
    out_size_error_r <= out_size_error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_count_r  <= '0;
      cand_closed_r <= 1'b0;
      ref_count_r   <= '0;
      all_matched_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      cand_count_r  <= cand_count_nxt;
      cand_closed_r <= cand_closed_nxt;
      ref_count_r   <= ref_count_nxt;
      all_matched_r <= all_matched_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_matched    = out_matched_r;
  assign out_size_error = out_size_error_r;

  // a report only comes from the finish of a last test transfer
  a_report_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(cmd_i.finish) && item_last_r && item_op_r == apm_pkg::OP_TEST))
    else $error("report without a finished last test");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (cand_count_r <= CNT_MAX + CNT_ONE) && (ref_count_r <= CNT_MAX + CNT_ONE))
    else $error("count beyond saturation");

  a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_matched_r && out_size_error_r))
    else $error("match reported with size error");

endmodule

`default_nettype wire

// File: bench/tb_attribute_predicate_match_top.sv
// tb_attribute_predicate_match_top: self-checking bench for the attribute predicate matcher
// drives load/test transfers from a backlog queue and scores every report against its own predictor
// depends on apm_pkg and attribute_predicate_match_top
`timescale 1ns / 1ps

module tb_attribute_predicate_match_top;

  localparam int MAX_ATTRS = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [apm_pkg::REL_W-1:0] REL_UNKNOWN = 4'hF;

  typedef logic [apm_pkg::KEY_W-1:0]        key_t;
  typedef logic [apm_pkg::REL_W-1:0]        rel_t;
  typedef logic signed [apm_pkg::VAL_W-1:0] val_t;

  typedef struct packed {
    logic                      op;
    logic [apm_pkg::KEY_W-1:0] key;
    logic [apm_pkg::REL_W-1:0] rel;
    logic [apm_pkg::VAL_W-1:0] val;
    logic                      last;
  } attr_xfer_t;

  typedef struct packed {
    logic matched;
    logic size_error;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = apm_pkg::OP_LOAD;
  logic [apm_pkg::KEY_W-1:0] in_attr_key = '0;
  logic [apm_pkg::REL_W-1:0] in_relation = apm_pkg::REL_IS;
  logic signed [apm_pkg::VAL_W-1:0] in_attr_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_matched;
  logic out_size_error;

  attribute_predicate_match_top #(.MAX_ATTRS(MAX_ATTRS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_attr_key   (in_attr_key),
    .in_relation   (in_relation),
    .in_attr_value (in_attr_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_matched   (out_matched),
    .out_size_error(out_size_error)
  );

  always #6 clk = ~clk;

  attr_xfer_t attr_backlog[$];
  verdict_t   verdicts_due[$];
  verdict_t   due;
  int idle_pct = 0;
  int queued_cnt = 0;
  int xfer_cnt = 0;
  int report_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  // predictor copy of the candidate store and set counters
  logic [apm_pkg::KEY_W-1:0]        cand_key[MAX_ATTRS];
  logic [apm_pkg::REL_W-1:0]        cand_rel[MAX_ATTRS];
  logic signed [apm_pkg::VAL_W-1:0] cand_val[MAX_ATTRS];
  int   cand_cnt = 0;
  logic cand_closed = 1'b0;
  int   ref_cnt = 0;
  logic all_hit = 1'b1;

  function automatic logic relation_holds(input logic [apm_pkg::REL_W-1:0] rel,
                                          input logic signed [apm_pkg::VAL_W-1:0] cval,
                                          input logic signed [apm_pkg::VAL_W-1:0] rval);
    case (rel)
      apm_pkg::REL_EQ:     return cval == rval;
      apm_pkg::REL_NE:     return cval != rval;
      apm_pkg::REL_GT:     return cval > rval;
      apm_pkg::REL_GE:     return cval >= rval;
      apm_pkg::REL_LT:     return cval < rval;
      apm_pkg::REL_LE:     return cval <= rval;
      apm_pkg::REL_EQ_ANY: return 1'b1;
      default:             return 1'b0;
    endcase
  endfunction

  task automatic score_attribute(input attr_xfer_t x);
    logic hit;
    logic err;
    int n;
    verdict_t v;
    if (x.op == apm_pkg::OP_LOAD) begin
      if (cand_closed) begin
        cand_cnt = 0;
        cand_closed = 1'b0;
      end
      if (cand_cnt < MAX_ATTRS) begin
        cand_key[cand_cnt] = x.key;
        cand_rel[cand_cnt] = x.rel;
        cand_val[cand_cnt] = x.val;
      end
      if (cand_cnt <= MAX_ATTRS) cand_cnt++;
      if (x.last) cand_closed = 1'b1;
    end else begin
      // a reference always closes the candidate set
      cand_closed = 1'b1;
      if (ref_cnt <= MAX_ATTRS) ref_cnt++;
      hit = (x.rel == apm_pkg::REL_IS);
      n = (cand_cnt < MAX_ATTRS) ? cand_cnt : MAX_ATTRS;
      for (int i = 0; i < n; i++) begin
        if (!hit && cand_key[i] == x.key && cand_rel[i] == apm_pkg::REL_IS &&
            relation_holds(x.rel, cand_val[i], x.val))
          hit = 1'b1;
      end
      if (!hit) all_hit = 1'b0;
      if (x.last) begin
        err = cand_cnt == 0 || cand_cnt > MAX_ATTRS || ref_cnt == 0 || ref_cnt > MAX_ATTRS;
        v.matched = all_hit && !err;
        v.size_error = err;
        verdicts_due.push_back(v);
        ref_cnt = 0;
        all_hit = 1'b1;
      end
    end
  endtask

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  task automatic queue_attr(input logic op, input logic [apm_pkg::KEY_W-1:0] key,
                            input logic [apm_pkg::REL_W-1:0] rel,
                            input logic [apm_pkg::VAL_W-1:0] val,
                            input logic last);
    attr_xfer_t x;
    x.op = op;
    x.key = key;
    x.rel = rel;
    x.val = val;
    x.last = last;
    attr_backlog.push_back(x);
    queued_cnt++;
  endtask

  // mostly well-formed candidate sets followed by reference sets probing them,
  // with a sprinkle of random noise transfers
  task automatic queue_random_sets(input int budget);
    int stop_at;
    int n_cand;
    int n_ref;
    int n_sets;
    int ncap;
    int k;
    key_t keys[MAX_ATTRS+3];
    val_t vals[MAX_ATTRS+3];
    key_t rkey;
    val_t rval;
    stop_at = queued_cnt + budget;
    while (queued_cnt < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(4, 1))
          queue_attr($urandom_range(1) ? apm_pkg::OP_TEST : apm_pkg::OP_LOAD,
                     key_t'($urandom_range(255)), rel_t'($urandom_range(15)),
                     val_t'($urandom_range(65535)), 1'($urandom_range(1)));
      end
      n_cand = ($urandom_range(9) == 0) ? $urandom_range(MAX_ATTRS + 3, MAX_ATTRS + 1)
                                        : $urandom_range(MAX_ATTRS, 1);
      for (int i = 0; i < n_cand; i++) begin
        keys[i] = ($urandom_range(3) != 0) ? key_t'(8'h10 + $urandom_range(3))
                                           : key_t'($urandom_range(255));
        case ($urandom_range(3))
          0: vals[i] = 16'sh7FFF;
          1: vals[i] = 16'sh8000;
          2: vals[i] = val_t'($urandom_range(8) - 4);
          default: vals[i] = val_t'($urandom_range(65535));
        endcase
        // unterminated sets are closed by the first reference
        queue_attr(apm_pkg::OP_LOAD, keys[i],
                   ($urandom_range(6) == 0) ? rel_t'($urandom_range(15)) : apm_pkg::REL_IS,
                   vals[i], i == n_cand - 1 && $urandom_range(9) != 0);
      end
      ncap = (n_cand < MAX_ATTRS) ? n_cand : MAX_ATTRS;
      n_sets = $urandom_range(3, 1);
      repeat (n_sets) begin
        case ($urandom_range(9))
          0: n_ref = $urandom_range(MAX_ATTRS + 2, MAX_ATTRS + 1);
          1, 2: n_ref = $urandom_range(MAX_ATTRS, 4);
          default: n_ref = $urandom_range(3, 1);
        endcase
        for (int j = 0; j < n_ref; j++) begin
          k = $urandom_range(ncap - 1);
          rkey = ($urandom_range(9) == 0) ? key_t'($urandom_range(255)) : keys[k];
          case ($urandom_range(5))
            0: rval = vals[k];
            1: rval = vals[k] + 16'sd1;
            2: rval = vals[k] - 16'sd1;
            3: rval = 16'sh7FFF;
            4: rval = 16'sh8000;
            default: rval = val_t'($urandom_range(65535));
          endcase
          queue_attr(apm_pkg::OP_TEST, rkey,
                     ($urandom_range(9) == 0) ? rel_t'($urandom_range(15, 8))
                                              : rel_t'($urandom_range(7)),
                     rval, j == n_ref - 1);
        end
      end
    end
  endtask

  // driver: present the next pending item once the current one is transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (attr_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        {in_op, in_attr_key, in_relation, in_attr_value, in_last} <= attr_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: score accepted transfers, then check any report strobe
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      score_attribute({in_op, in_attr_key, in_relation, in_attr_value, in_last});
      xfer_cnt++;
    end
    if (rst_n && out_valid) begin
      report_cnt++;
      if (verdicts_due.size() == 0) begin
        note_failure("report strobe with no report pending");
      end else begin
        due = verdicts_due.pop_front();
        if (out_matched !== due.matched || out_size_error !== due.size_error)
          note_failure($sformatf("report %0d: want matched=%0b size_error=%0b, got %0b %0b",
                                 report_cnt, due.matched, due.size_error,
                                 out_matched, out_size_error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d reports pending", cycle_cnt,
               verdicts_due.size());
      $display("FAIL attribute_predicate_match_top");
      $finish;
    end
  end

  initial begin
    // directed: reference with no candidates ever loaded
    queue_attr(apm_pkg::OP_TEST, 8'h10, apm_pkg::REL_EQ, 16'sd0, 1'b1);
    queue_attr(apm_pkg::OP_LOAD, 8'h00, apm_pkg::REL_IS, 16'sh8000, 1'b0);
    queue_attr(apm_pkg::OP_LOAD, 8'hFF, apm_pkg::REL_IS, 16'sh7FFF, 1'b0);
    queue_attr(apm_pkg::OP_LOAD, 8'h10, apm_pkg::REL_IS, 16'sd0, 1'b0);
    queue_attr(apm_pkg::OP_LOAD, 8'h10, apm_pkg::REL_EQ, 16'sd5, 1'b1);
    // one single-reference set per relation
    queue_attr(apm_pkg::OP_TEST, 8'h55, apm_pkg::REL_IS, 16'sd1234, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'hFF, apm_pkg::REL_EQ, 16'sh7FFF, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'h10, apm_pkg::REL_NE, 16'sd5, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'h00, apm_pkg::REL_GT, 16'sh8000, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'h00, apm_pkg::REL_GE, 16'sh8000, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'hFF, apm_pkg::REL_LT, 16'sh7FFF, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'hFF, apm_pkg::REL_LE, 16'sh7FFF, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'h10, apm_pkg::REL_EQ_ANY, 16'sd0, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'h10, REL_UNKNOWN, 16'sd0, 1'b1);
    // key hit on a candidate that is not an IS entry
    queue_attr(apm_pkg::OP_TEST, 8'h10, apm_pkg::REL_EQ, 16'sd5, 1'b1);
    // new candidate set left open, references close it
    queue_attr(apm_pkg::OP_LOAD, 8'h20, apm_pkg::REL_IS, 16'sd100, 1'b0);
    queue_attr(apm_pkg::OP_LOAD, 8'h21, apm_pkg::REL_IS, -16'sd1, 1'b0);
    queue_attr(apm_pkg::OP_TEST, 8'h20, apm_pkg::REL_GT, 16'sd99, 1'b0);
    queue_attr(apm_pkg::OP_TEST, 8'h21, apm_pkg::REL_EQ, 16'sd5, 1'b1);
    queue_attr(apm_pkg::OP_TEST, 8'h21, apm_pkg::REL_LT, 16'sd0, 1'b1);
    queue_random_sets(340);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sender idle mixes; the result side has no stall to exercise
    while (attr_backlog.size() != 0) @(posedge clk);
    idle_pct = 72;
    queue_random_sets(370);
    while (attr_backlog.size() != 0) @(posedge clk);
    idle_pct = 15;
    queue_random_sets(370);

    while (attr_backlog.size() != 0 || start || busy || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (MAX_ATTRS + 6) @(posedge clk);
    if (verdicts_due.size() != 0)
      note_failure($sformatf("%0d reports never arrived", verdicts_due.size()));

    $display("covered %0d load/test transfers and %0d set reports", xfer_cnt, report_cnt);
    $display("over back-to-back, 72%% and 15%% sender idle mixes; %0d failures", fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASS attribute_predicate_match_top");
    end else begin
      $display("FAIL attribute_predicate_match_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/apm_pkg.sv
hdl/apm_ctrl.sv
hdl/apm_datapath.sv
hdl/attribute_predicate_match_top.sv
bench/tb_attribute_predicate_match_top.sv
